FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define R2Q_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("r2q check failed");

// Next-cycle implication.
`define R2Q_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("r2q check failed");

`endif

FILE: sv/r2q_pkg.sv
// Package for the rotation matrix to quaternion block: defaults and case codes.
package r2q_pkg;

   localparam int DEF_FRAC_BITS  = 14;
   localparam int DEF_WORD_WIDTH = 16;

   localparam logic [1:0] CASE_W = 2'd0;
   localparam logic [1:0] CASE_X = 2'd1;
   localparam logic [1:0] CASE_Y = 2'd2;
   localparam logic [1:0] CASE_Z = 2'd3;

endpackage

FILE: sv/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to quaternion converter (Shepperd), fully pipelined.
// One matrix enters per clock and one quaternion leaves per clock. The pipeline
// is one input register (case select, radicand and difference
// terms), NS square-root stages producing one root bit each, where
// NS = ceil((RW - 1 + FRAC_BITS) / 2) and RW = max(FRAC_BITS + 2, WORD_WIDTH) + 3,
// then a divider input register, ND = WORD_WIDTH + 1 + FRAC_BITS restoring-divider
// stages running the three quotients side by side one bit each, and an output
// register that saturates and orders the components. At the defaults (Q2.14,
// 16 bits) that is 16 root stages and 31 divider stages.
// When the output item is held by rsp_stall the whole pipeline freezes.
module rotation_matrix_to_quaternion_top
   import r2q_pkg::*;
#(
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [WORD_WIDTH-1:0] req_m00,
   input  logic signed [WORD_WIDTH-1:0] req_m01,
   input  logic signed [WORD_WIDTH-1:0] req_m02,
   input  logic signed [WORD_WIDTH-1:0] req_m10,
   input  logic signed [WORD_WIDTH-1:0] req_m11,
   input  logic signed [WORD_WIDTH-1:0] req_m12,
   input  logic signed [WORD_WIDTH-1:0] req_m20,
   input  logic signed [WORD_WIDTH-1:0] req_m21,
   input  logic signed [WORD_WIDTH-1:0] req_m22,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [WORD_WIDTH-1:0] rsp_qw,
   output logic signed [WORD_WIDTH-1:0] rsp_qx,
   output logic signed [WORD_WIDTH-1:0] rsp_qy,
   output logic signed [WORD_WIDTH-1:0] rsp_qz,
   output logic [1:0]                   rsp_major_case,
   output logic                         rsp_degenerate
);

   localparam int W   = WORD_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int EW  = (F + 2 > W) ? F + 2 : W;
   localparam int RW  = EW + 3;            // radicand, signed
   localparam int XW  = RW - 1 + F;        // shifted radicand
   localparam int NS  = (XW + 1) / 2;      // root bits = sqrt stages
   localparam int XPW = 2 * NS;
   localparam int DW  = W + 1;             // difference terms, signed
   localparam int ND  = DW + F;            // quotient bits = divider stages
   localparam int CW  = NS + ND;           // compare width for saturation
   localparam longint ONE_L = longint'(1) << F;
   localparam logic [CW-1:0] WMAX = CW'((longint'(1) << (W - 1)) - 1);
   localparam logic [CW-1:0] WMAG = CW'(longint'(1) << (W - 1));

   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // ---------------- input stage ----------------
   logic signed [RW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, trace, rad;
   logic signed [DW-1:0] d0_c, d1_c, d2_c;
   logic [1:0]           maj_c;
   logic                 dg_c;
   logic [XPW-1:0]       x_c;

   always_comb begin
      a00 = RW'(req_m00); a01 = RW'(req_m01); a02 = RW'(req_m02);
      a10 = RW'(req_m10); a11 = RW'(req_m11); a12 = RW'(req_m12);
      a20 = RW'(req_m20); a21 = RW'(req_m21); a22 = RW'(req_m22);
      trace = a00 + a11 + a22;
      priority if (trace > 0) begin
         maj_c = CASE_W;
         rad   = RW'(ONE_L) + trace;
         d0_c  = DW'(a21 - a12);
         d1_c  = DW'(a02 - a20);
         d2_c  = DW'(a10 - a01);
      end else if (a00 > a11 && a00 > a22) begin
         maj_c = CASE_X;
         rad   = RW'(ONE_L) + a00 - a11 - a22;
         d0_c  = DW'(a21 - a12);
         d1_c  = DW'(a01 + a10);
         d2_c  = DW'(a02 + a20);
      end else if (a11 > a22) begin
         maj_c = CASE_Y;
         rad   = RW'(ONE_L) + a11 - a00 - a22;
         d0_c  = DW'(a02 - a20);
         d1_c  = DW'(a01 + a10);
         d2_c  = DW'(a12 + a21);
      end else begin
         maj_c = CASE_Z;
         rad   = RW'(ONE_L) + a22 - a00 - a11;
         d0_c  = DW'(a10 - a01);
         d1_c  = DW'(a02 + a20);
         d2_c  = DW'(a12 + a21);
      end
      dg_c = (rad <= 0);
      x_c  = dg_c ? '0 : (XPW'(rad[RW-2:0]) << F);
   end

   // ---------------- square root stages ----------------
   // index 0 is the input register, index k+1 the result of root step k
   logic                 sq_v_ff    [0:NS];
   logic [XPW-1:0]       sq_x_ff    [0:NS];
   logic [NS+2:0]        sq_rem_ff  [0:NS];
   logic [NS-1:0]        sq_root_ff [0:NS];
   logic signed [DW-1:0] sq_d0_ff   [0:NS];
   logic signed [DW-1:0] sq_d1_ff   [0:NS];
   logic signed [DW-1:0] sq_d2_ff   [0:NS];
   logic [1:0]           sq_maj_ff  [0:NS];
   logic                 sq_dg_ff   [0:NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (advance) begin
         sq_v_ff[0] <= req_valid;
      end
      if (advance) begin
         sq_x_ff[0]    <= x_c;
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_d0_ff[0]   <= d0_c;
         sq_d1_ff[0]   <= d1_c;
         sq_d2_ff[0]   <= d2_c;
         sq_maj_ff[0]  <= maj_c;
         sq_dg_ff[0]   <= dg_c;
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_sqrt
      logic [NS+2:0] rem_t, trial_t, rem_in;
      logic [NS-1:0] root_in;
      always_comb begin
         rem_t   = {sq_rem_ff[k][NS:0], sq_x_ff[k][XPW-1:XPW-2]};
         trial_t = (NS+3)'({sq_root_ff[k], 2'b01});
         if (rem_t >= trial_t) begin
            rem_in  = rem_t - trial_t;
            root_in = {sq_root_ff[k][NS-2:0], 1'b1};
         end else begin
            rem_in  = rem_t;
            root_in = {sq_root_ff[k][NS-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (advance) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
         if (advance) begin
            sq_x_ff[k+1]    <= sq_x_ff[k] << 2;
            sq_rem_ff[k+1]  <= rem_in;
            sq_root_ff[k+1] <= root_in;
            sq_d0_ff[k+1]   <= sq_d0_ff[k];
            sq_d1_ff[k+1]   <= sq_d1_ff[k];
            sq_d2_ff[k+1]   <= sq_d2_ff[k];
            sq_maj_ff[k+1]  <= sq_maj_ff[k];
            sq_dg_ff[k+1]   <= sq_dg_ff[k];
         end
      end
   end

   // ---------------- divider stages ----------------
   // three restoring dividers, |d| * 2^F / (2 * root), one quotient bit per stage
   logic              dv_v_ff    [0:ND];
   logic [NS-1:0]     dv_root_ff [0:ND];
   logic [ND-1:0]     dv_num_ff  [0:ND][3];
   logic [NS+1:0]     dv_rem_ff  [0:ND][3];
   logic [ND-1:0]     dv_q_ff    [0:ND][3];
   logic [2:0]        dv_neg_ff  [0:ND];
   logic [1:0]        dv_maj_ff  [0:ND];
   logic              dv_dg_ff   [0:ND];

   logic signed [DW-1:0] dsrc [3];
   logic [DW-1:0]        dmag [3];
   always_comb begin
      dsrc[0] = sq_d0_ff[NS];
      dsrc[1] = sq_d1_ff[NS];
      dsrc[2] = sq_d2_ff[NS];
      for (int i = 0; i < 3; i++) begin
         dmag[i] = dsrc[i][DW-1] ? DW'(-dsrc[i]) : DW'(dsrc[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (advance) begin
         dv_v_ff[0] <= sq_v_ff[NS];
      end
      if (advance) begin
         dv_root_ff[0] <= sq_root_ff[NS];
         for (int i = 0; i < 3; i++) begin
            dv_num_ff[0][i]  <= {dmag[i], F'(0)};
            dv_rem_ff[0][i]  <= '0;
            dv_q_ff[0][i]    <= '0;
            dv_neg_ff[0][i]  <= dsrc[i][DW-1];
         end
         dv_maj_ff[0] <= sq_maj_ff[NS];
         dv_dg_ff[0]  <= sq_dg_ff[NS];
      end
   end

   for (genvar j = 0; j < ND; j++) begin : g_div
      logic [NS+1:0] den;
      logic [NS+1:0] rem_t  [3];
      logic [NS+1:0] rem_in [3];
      logic [2:0]    qbit;
      always_comb begin
         den = (NS+2)'({dv_root_ff[j], 1'b0});
         for (int i = 0; i < 3; i++) begin
            rem_t[i] = {dv_rem_ff[j][i][NS:0], dv_num_ff[j][i][ND-1]};
            qbit[i]  = (rem_t[i] >= den);
            rem_in[i] = qbit[i] ? rem_t[i] - den : rem_t[i];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else if (advance) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
         if (advance) begin
            dv_root_ff[j+1] <= dv_root_ff[j];
            for (int i = 0; i < 3; i++) begin
               dv_num_ff[j+1][i] <= dv_num_ff[j][i] << 1;
               dv_rem_ff[j+1][i] <= rem_in[i];
               dv_q_ff[j+1][i]   <= {dv_q_ff[j][i][ND-2:0], qbit[i]};
            end
            dv_neg_ff[j+1] <= dv_neg_ff[j];
            dv_maj_ff[j+1] <= dv_maj_ff[j];
            dv_dg_ff[j+1]  <= dv_dg_ff[j];
         end
      end
   end

   // ---------------- output stage ----------------
   logic [CW-1:0]         qwide [3];
   logic signed [W-1:0]   qsat  [3];
   logic [CW-1:0]         mwide;
   logic signed [W-1:0]   msat;
   logic signed [W-1:0]   qw_in, qx_in, qy_in, qz_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qwide[i] = CW'(dv_q_ff[ND][i]);
         if (dv_dg_ff[ND]) begin
            qsat[i] = '0;
         end else if (dv_neg_ff[ND][i]) begin
            qsat[i] = (qwide[i] > WMAG) ? W'(WMAG) : W'(-qwide[i]);
         end else begin
            qsat[i] = (qwide[i] > WMAX) ? W'(WMAX) : W'(qwide[i]);
         end
      end
      mwide = CW'(dv_root_ff[ND] >> 1);
      msat  = (mwide > WMAX) ? W'(WMAX) : W'(mwide);
      unique case (dv_maj_ff[ND])
         CASE_W: begin
            qw_in = msat;    qx_in = qsat[0]; qy_in = qsat[1]; qz_in = qsat[2];
         end
         CASE_X: begin
            qw_in = qsat[0]; qx_in = msat;    qy_in = qsat[1]; qz_in = qsat[2];
         end
         CASE_Y: begin
            qw_in = qsat[0]; qx_in = qsat[1]; qy_in = msat;    qz_in = qsat[2];
         end
         default: begin
            qw_in = qsat[0]; qx_in = qsat[1]; qy_in = qsat[2]; qz_in = msat;
         end
      endcase
   end

   logic                rsp_valid_ff;
   logic signed [W-1:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic [1:0]          maj_ff;
   logic                dg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_v_ff[ND];
      end
      if (advance) begin
         qw_ff  <= qw_in;
         qx_ff  <= qx_in;
         qy_ff  <= qy_in;
         qz_ff  <= qz_in;
         maj_ff <= dv_maj_ff[ND];
         dg_ff  <= dv_dg_ff[ND];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_qw         = qw_ff;
   assign rsp_qx         = qx_ff;
   assign rsp_qy         = qy_ff;
   assign rsp_qz         = qz_ff;
   assign rsp_major_case = maj_ff;
   assign rsp_degenerate = dg_ff;

endmodule

FILE: sv/r2q_checker.sv
// Port-level checks for the rotation matrix to quaternion block, bound to the top.
`include "assert_macros.svh"

module r2q_checker
   import r2q_pkg::*;
#(
   parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [WORD_WIDTH-1:0] rsp_qw,
   input logic [WORD_WIDTH-1:0] rsp_qx,
   input logic [WORD_WIDTH-1:0] rsp_qy,
   input logic [WORD_WIDTH-1:0] rsp_qz,
   input logic [1:0]            rsp_major_case,
   input logic                  rsp_degenerate
);

   // a held item stays on the port
   `R2Q_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_qw) && $stable(rsp_qx) && $stable(rsp_qy) && $stable(rsp_qz))

   // degenerate items carry an all-zero quaternion
   `R2Q_ASSERT_IMP(a_degen_zero, rsp_valid && rsp_degenerate, rsp_qw == '0 && rsp_qx == '0 && rsp_qy == '0 && rsp_qz == '0)

   // the major component comes from a root and is never negative
   `R2Q_ASSERT_IMP(a_major_pos, rsp_valid, (rsp_major_case == CASE_W && !rsp_qw[WORD_WIDTH-1]) || (rsp_major_case == CASE_X && !rsp_qx[WORD_WIDTH-1]) || (rsp_major_case == CASE_Y && !rsp_qy[WORD_WIDTH-1]) || (rsp_major_case == CASE_Z && !rsp_qz[WORD_WIDTH-1]))

   // input is only back-pressured while an output item is held
   `R2Q_ASSERT_IMP(a_stall_src, req_stall, rsp_valid && rsp_stall)

endmodule

bind rotation_matrix_to_quaternion_top r2q_checker #(
   .WORD_WIDTH(WORD_WIDTH)
) u_r2q_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_qw         (rsp_qw),
   .rsp_qx         (rsp_qx),
   .rsp_qy         (rsp_qy),
   .rsp_qz         (rsp_qz),
   .rsp_major_case (rsp_major_case),
   .rsp_degenerate (rsp_degenerate)
);
